@@ rtl/core/pfsr_pkg.sv @@
// Package for the PCM FIFO sound register block: opcodes, register offsets,
// widths and the control structs passed between the top level, FIFOs and cells.
// Depends on nothing.
`default_nettype none

package pfsr_pkg;

    localparam int FIFO_DEPTH_DEFAULT = 32;
    localparam int NUM_SOUND_REGS     = 20;
    localparam int SND_IDX_W          = $clog2(NUM_SOUND_REGS);

    localparam int THRESH_W           = 6;
    localparam logic [THRESH_W-1:0] THRESH_RESET = 6'd16;

    localparam int IN_TDATA_W  = 32;
    localparam int IN_TUSER_W  = 2;
    localparam int RESULT_W    = 33;
    localparam int OUT_TDATA_W = 40;

    // Byte offsets within the io page
    localparam logic [7:0] ADDR_SND_LO  = 8'h60;
    localparam logic [7:0] ADDR_SND_HI  = 8'h86;
    localparam logic [7:0] ADDR_MIX     = 8'h82;
    localparam logic [7:0] ADDR_MASTER  = 8'h84;
    localparam logic [7:0] ADDR_BIAS    = 8'h88;
    localparam logic [7:0] ADDR_FIFO_A0 = 8'hA0;
    localparam logic [7:0] ADDR_FIFO_A1 = 8'hA2;
    localparam logic [7:0] ADDR_FIFO_B0 = 8'hA4;
    localparam logic [7:0] ADDR_FIFO_B1 = 8'hA6;

    localparam logic [15:0] MIX_KEEP_MASK   = 16'h77FF;
    localparam int          MIX_CLR_A_BIT   = 11;
    localparam int          MIX_CLR_B_BIT   = 15;
    localparam int          MASTER_EN_BIT   = 7;
    localparam logic [15:0] MASTER_EN_VALUE = 16'h0080;

    typedef enum logic [1:0] {
        OP_READ   = 2'd0,
        OP_WRITE  = 2'd1,
        OP_TICK_A = 2'd2,
        OP_TICK_B = 2'd3
    } op_t;

    // Per-item command to one FIFO
    typedef struct packed {
        logic        push;
        logic        pop;
        logic        clear;
        logic [15:0] data;
    } fifo_ctrl_t;

    // Per-cycle command to one storage cell
    typedef struct packed {
        logic shift;
        logic load_lo;
        logic load_hi;
    } cell_ctrl_t;

    // One result item, last field in the lowest bits
    typedef struct packed {
        logic       dma_request;
        logic [7:0] sample_b;
        logic [7:0] sample_a;
        logic [15:0] read_data;
    } result_t;

endpackage

`default_nettype wire

@@ rtl/core/pfsr_cell.sv @@
// One byte cell of the sample FIFO chain.
// Depends on pfsr_pkg for the cell control struct.
`default_nettype none

module pfsr_cell (
    input  wire logic                clk,
    input  wire pfsr_pkg::cell_ctrl_t ctrl,
    input  wire logic [7:0]          shift_in,
    input  wire logic [7:0]          lo_byte,
    input  wire logic [7:0]          hi_byte,
    output logic [7:0]               data
);
    import pfsr_pkg::*;

    logic [7:0] data_reg;
    logic [7:0] data_next;

    // Shift towards the head on a pop, else take a pushed byte, else hold
    always_comb
    begin
        data_next = data_reg;
        if (ctrl.shift)
        begin
            data_next = shift_in;
        end
        else if (ctrl.load_lo)
        begin
            data_next = lo_byte;
        end
        else if (ctrl.load_hi)
        begin
            data_next = hi_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

`default_nettype wire

@@ rtl/core/pfsr_fifo.sv @@
// Sample FIFO built as a chain of byte cells with the oldest byte in cell 0,
// plus its fill count. Depends on pfsr_pkg and pfsr_cell.
`default_nettype none

module pfsr_fifo #(
    parameter int DEPTH = pfsr_pkg::FIFO_DEPTH_DEFAULT,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire pfsr_pkg::fifo_ctrl_t ctrl,
    output logic [CNT_W-1:0]          count,
    output logic [7:0]                head
);
    import pfsr_pkg::*;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [7:0]       cell_data [DEPTH];
    logic             space_lo;
    logic             space_hi;

    assign space_lo = (count_reg != CNT_W'(DEPTH));
    assign space_hi = (count_reg < CNT_W'(DEPTH - 1));

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.clear)
        begin
            count_next = '0;
        end
        else if (ctrl.push)
        begin
            count_next = count_reg + CNT_W'(space_lo) + CNT_W'(space_hi);
        end
        else if (ctrl.pop && (count_reg != '0))
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        cell_ctrl_t cc;
        logic [7:0] from_up;

        // Low byte lands in the first free cell, high byte in the one after
        assign cc.shift   = ctrl.pop && !ctrl.clear;
        assign cc.load_lo = ctrl.push && (count_reg == CNT_W'(i));
        if (i == 0)
        begin : g_head
            assign cc.load_hi = 1'b0;
        end
        else
        begin : g_body
            assign cc.load_hi = ctrl.push && (count_reg == CNT_W'(i - 1));
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign from_up = cell_data[i];
        end
        else
        begin : g_link
            assign from_up = cell_data[i + 1];
        end

        pfsr_cell u_cell (
            .clk      (clk),
            .ctrl     (cc),
            .shift_in (from_up),
            .lo_byte  (ctrl.data[7:0]),
            .hi_byte  (ctrl.data[15:8]),
            .data     (cell_data[i])
        );
    end

    assign count = count_reg;
    assign head  = cell_data[0];

endmodule

`default_nettype wire

@@ rtl/core/pcm_fifo_sound_register_block.sv @@
// Top level of the PCM FIFO sound register block: bus decode, sound registers,
// two sample FIFOs and a two-entry output stage. Depends on pfsr_pkg, pfsr_fifo.
//
// The block takes one transfer per cycle on the slave stream: a bus read, a bus
// write or a timer tick for channel A or B, selected by s_axis_tuser. Every
// transfer yields exactly one result on the master stream, registered as it is
// taken when the output register is free, else parked while the receiver holds
// m_axis_tready low. Each result carries the read data (zero unless a read),
// both current samples as they stand after the item, and the DMA refill
// request of a tick. The sustained rate is one item per clock: each item is a
// single register update or a FIFO step on the cell chain, and the two-entry
// output stage keeps s_axis_tready high while one result waits; the input
// stalls only once a second result is parked behind a stalled one. Offsets
// 0x60-0x86 are twenty sound registers (0x82 is the mix word, whose bits 11
// and 15 empty FIFO A or B and are not stored; 0x84 keeps only master enable
// bit 7); 0x88 is the bias word; writes to 0xA0/0xA2 and 0xA4/0xA6 push the
// low then the high byte into FIFO A or B, and a byte pushed into a full FIFO
// is dropped. A tick pops the oldest byte as the channel's sample, or holds
// the sample when the FIFO is empty, and requests a refill when the fill left
// is below refill_threshold and dma_refill_enabled is set. Write the threshold
// on the cfg channel only while the block is idle. No clearing pass follows
// reset: FIFO contents are reached only through their fill counts, which
// reset clears.
`default_nettype none

module pcm_fifo_sound_register_block #(
    parameter int FIFO_DEPTH = pfsr_pkg::FIFO_DEPTH_DEFAULT
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // Threshold write channel
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [pfsr_pkg::THRESH_W-1:0]   cfg_data,
    // Item input
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [7:0] address, [23:8] write_data, [24] dma_refill_enabled, rest zero
    input  wire logic [pfsr_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    // [1:0] opcode
    input  wire logic [pfsr_pkg::IN_TUSER_W-1:0] s_axis_tuser,
    // Result output
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // [15:0] read_data, [23:16] sample_a, [31:24] sample_b, [32] dma_request
    output logic [pfsr_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
    import pfsr_pkg::*;

    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam int CMP_W = (CNT_W > THRESH_W) ? CNT_W : THRESH_W;

    // Architectural state
    logic [15:0]         sound_regs_reg [NUM_SOUND_REGS];
    logic [15:0]         bias_reg;
    logic                master_enable_reg;
    logic [15:0]         mix_control_reg;
    logic [7:0]          sample_a_reg;
    logic [7:0]          sample_b_reg;
    logic [THRESH_W-1:0] thresh_reg;

    // Output stage
    result_t out_reg;
    result_t out_next;
    logic    out_valid_reg;
    logic    out_valid_next;
    result_t skid_reg;
    result_t skid_next;
    logic    skid_valid_reg;
    logic    skid_valid_next;

    // Decoded item
    op_t         op;
    logic [7:0]  addr;
    logic [15:0] wdata;
    logic        dma_on;
    logic        in_xfer;
    logic        out_take;
    logic [7:0]  snd_off;
    logic [SND_IDX_W-1:0] snd_idx;
    logic        snd_hit;

    fifo_ctrl_t       fctl_a;
    fifo_ctrl_t       fctl_b;
    logic [CNT_W-1:0] count_a;
    logic [CNT_W-1:0] count_b;
    logic [7:0]       head_a;
    logic [7:0]       head_b;
    logic [CNT_W-1:0] left_a;
    logic [CNT_W-1:0] left_b;

    result_t     res;
    logic [7:0]  sample_a_next;
    logic [7:0]  sample_b_next;

    assign op      = op_t'(s_axis_tuser[1:0]);
    assign addr    = s_axis_tdata[7:0];
    assign wdata   = s_axis_tdata[23:8];
    assign dma_on  = s_axis_tdata[24];

    assign s_axis_tready = !skid_valid_reg;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_take      = out_valid_reg && m_axis_tready;
    assign cfg_ready     = 1'b1;

    // Odd offsets share the register of the even offset below them
    assign snd_off = addr - ADDR_SND_LO;
    assign snd_idx = snd_off[SND_IDX_W:1];
    assign snd_hit = addr inside {[ADDR_SND_LO:ADDR_SND_HI]};

    // Fill left after a pop
    assign left_a = (count_a != '0) ? count_a - CNT_W'(1) : count_a;
    assign left_b = (count_b != '0) ? count_b - CNT_W'(1) : count_b;

    // FIFO commands for this item
    always_comb
    begin
        fctl_a = '{push: 1'b0, pop: 1'b0, clear: 1'b0, data: wdata};
        fctl_b = '{push: 1'b0, pop: 1'b0, clear: 1'b0, data: wdata};
        if (in_xfer)
        begin
            case (op)
                OP_WRITE:
                begin
                    fctl_a.push  = (addr == ADDR_FIFO_A0) || (addr == ADDR_FIFO_A1);
                    fctl_b.push  = (addr == ADDR_FIFO_B0) || (addr == ADDR_FIFO_B1);
                    fctl_a.clear = (addr == ADDR_MIX) && wdata[MIX_CLR_A_BIT];
                    fctl_b.clear = (addr == ADDR_MIX) && wdata[MIX_CLR_B_BIT];
                end
                OP_TICK_A: fctl_a.pop = 1'b1;
                OP_TICK_B: fctl_b.pop = 1'b1;
                default:   ;
            endcase
        end
    end

    // Result of this item, from the state before it
    always_comb
    begin
        res           = '0;
        sample_a_next = sample_a_reg;
        sample_b_next = sample_b_reg;
        case (op)
            OP_READ:
            begin
                if (addr == ADDR_BIAS)
                begin
                    res.read_data = bias_reg;
                end
                else if (addr == ADDR_MASTER)
                begin
                    res.read_data = master_enable_reg ? MASTER_EN_VALUE : 16'd0;
                end
                else if (addr == ADDR_MIX)
                begin
                    res.read_data = mix_control_reg;
                end
                else if (snd_hit)
                begin
                    res.read_data = sound_regs_reg[snd_idx];
                end
            end
            OP_TICK_A:
            begin
                if (count_a != '0)
                begin
                    sample_a_next = head_a;
                end
                res.dma_request = dma_on && (CMP_W'(left_a) < CMP_W'(thresh_reg));
            end
            OP_TICK_B:
            begin
                if (count_b != '0)
                begin
                    sample_b_next = head_b;
                end
                res.dma_request = dma_on && (CMP_W'(left_b) < CMP_W'(thresh_reg));
            end
            default: ;
        endcase
        res.sample_a = sample_a_next;
        res.sample_b = sample_b_next;
    end

    // Register writes and current samples
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SOUND_REGS; i++)
            begin
                sound_regs_reg[i] <= '0;
            end
            bias_reg          <= '0;
            master_enable_reg <= 1'b0;
            mix_control_reg   <= '0;
            sample_a_reg      <= '0;
            sample_b_reg      <= '0;
            thresh_reg        <= THRESH_RESET;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                thresh_reg <= cfg_data;
            end
            if (in_xfer)
            begin
                sample_a_reg <= sample_a_next;
                sample_b_reg <= sample_b_next;
                if (op == OP_WRITE)
                begin
                    if (addr == ADDR_BIAS)
                    begin
                        bias_reg <= wdata;
                    end
                    else if (addr == ADDR_MASTER)
                    begin
                        master_enable_reg <= wdata[MASTER_EN_BIT];
                    end
                    else if (addr == ADDR_MIX)
                    begin
                        mix_control_reg <= wdata & MIX_KEEP_MASK;
                    end
                    else if (snd_hit)
                    begin
                        sound_regs_reg[snd_idx] <= wdata;
                    end
                end
            end
        end
    end

    pfsr_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo_a (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (fctl_a),
        .count (count_a),
        .head  (head_a)
    );

    pfsr_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo_b (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (fctl_b),
        .count (count_b),
        .head  (head_b)
    );

    // Output register with a skid entry: park a new result while one waits
    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || out_take)
        begin
            out_valid_next  = skid_valid_reg || in_xfer;
            out_next        = skid_valid_reg ? skid_reg : res;
            skid_valid_next = 1'b0;
        end
        else if (in_xfer)
        begin
            skid_next       = res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(OUT_TDATA_W - RESULT_W)'(0), out_reg};

endmodule

`default_nettype wire

@@ rtl/core/pfsr_checker.sv @@
// Port-level checks of the PCM FIFO sound register block's output stage,
// bound to the top level. Depends on pfsr_pkg.
`default_nettype none

module pfsr_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            s_axis_tvalid,
    input wire logic                            s_axis_tready,
    input wire logic                            m_axis_tvalid,
    input wire logic                            m_axis_tready,
    input wire logic [pfsr_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import pfsr_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed or dropped");

    // Input stalls only while a result is waiting
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no result pending");

    // After every input transfer a result is valid in the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> m_axis_tvalid)
        else $error("no result after input transfer");

    // No result appears without an input transfer
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        (!m_axis_tvalid && !(s_axis_tvalid && s_axis_tready)) |=> !m_axis_tvalid)
        else $error("result without input transfer");

    // A second result behind a stalled one fills the skid entry
    a_skid_full: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready && s_axis_tvalid && s_axis_tready)
        |=> !s_axis_tready)
        else $error("skid entry not marked full");

endmodule

bind pcm_fifo_sound_register_block pfsr_checker u_pfsr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

@@ test/testbench.sv @@
// Self-checking testbench for pcm_fifo_sound_register_block: directed and random
// bus reads, bus writes and timer ticks, checked against an in-bench predictor.
// Depends on pfsr_pkg and the block's RTL.
`timescale 1ns / 100ps

module testbench;

    import pfsr_pkg::*;

    localparam int FIFO_SLOTS    = FIFO_DEPTH_DEFAULT;
    localparam int CYCLE_LIMIT   = 200000;
    // Cycles to let the output stage settle once nothing is awaited any more
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASE_ITEMS   = 125;

    // Clock, reset and the block's inputs, all known from time zero
    logic                   clk;
    logic                   rst_n          = 1'b0;
    logic                   cfg_valid      = 1'b0;
    logic [THRESH_W-1:0]    cfg_data       = '0;
    logic                   s_axis_tvalid  = 1'b0;
    // [7:0] address, [23:8] write_data, [24] dma_refill_enabled, rest zero
    logic [IN_TDATA_W-1:0]  s_axis_tdata   = '0;
    // [1:0] opcode
    logic [IN_TUSER_W-1:0]  s_axis_tuser   = '0;
    logic                   m_axis_tready  = 1'b0;

    logic                   cfg_ready;
    logic                   s_axis_tready;
    logic                   m_axis_tvalid;
    // [15:0] read_data, [23:16] sample_a, [31:24] sample_b, [32] dma_request
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    // Idle rates in percent, changed between phases
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;

    int fail_count      = 0;
    int cycle_count     = 0;
    int items_sent      = 0;
    int results_checked = 0;
    int ticks_sent      = 0;
    int refills_seen    = 0;

    // Predicted state of the block
    logic [15:0]     snd_regs [NUM_SOUND_REGS];
    logic [15:0]     bias_word;
    logic            master_on;
    logic [15:0]     mix_word;
    logic [7:0]      fifo_mem  [2][FIFO_SLOTS];
    int              fifo_fill [2];
    int              fifo_head [2];
    logic [7:0]      cur_sample[2];
    int unsigned     refill_level;

    // Results still to come, oldest first
    result_t         awaited_results[$];

    pcm_fifo_sound_register_block #(
        .FIFO_DEPTH(FIFO_SLOTS)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Run out of patience if the block stops answering
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    // Push one byte; drop it when the FIFO is full
    function automatic void push_sample_byte(input int ch, input logic [7:0] b);
        if (fifo_fill[ch] < FIFO_SLOTS)
        begin
            fifo_mem[ch][(fifo_head[ch] + fifo_fill[ch]) % FIFO_SLOTS] = b;
            fifo_fill[ch]++;
        end
    endfunction

    // Advance the predicted state by one item and return the result it gives
    function automatic result_t predict_result(input op_t op, input logic [7:0] addr,
                                               input logic [15:0] wdata, input logic dma);
        result_t r;
        int      ch;
        r = '0;
        case (op)
            OP_READ:
            begin
                if (addr == ADDR_BIAS)
                    r.read_data = bias_word;
                else if (addr == ADDR_MASTER)
                    r.read_data = master_on ? MASTER_EN_VALUE : 16'h0000;
                else if (addr == ADDR_MIX)
                    r.read_data = mix_word;
                else if (addr >= ADDR_SND_LO && addr <= ADDR_SND_HI)
                    r.read_data = snd_regs[(addr - ADDR_SND_LO) >> 1];
            end
            OP_WRITE:
            begin
                if (addr == ADDR_BIAS)
                    bias_word = wdata;
                else if (addr == ADDR_FIFO_A0 || addr == ADDR_FIFO_A1 ||
                         addr == ADDR_FIFO_B0 || addr == ADDR_FIFO_B1)
                begin
                    // Low byte first, then high byte
                    ch = (addr == ADDR_FIFO_B0 || addr == ADDR_FIFO_B1) ? 1 : 0;
                    push_sample_byte(ch, wdata[7:0]);
                    push_sample_byte(ch, wdata[15:8]);
                end
                else if (addr == ADDR_MASTER)
                    master_on = wdata[MASTER_EN_BIT];
                else if (addr == ADDR_MIX)
                begin
                    // Clear bits empty the FIFOs and are never stored
                    if (wdata[MIX_CLR_A_BIT])
                    begin
                        fifo_fill[0] = 0;
                        fifo_head[0] = 0;
                    end
                    if (wdata[MIX_CLR_B_BIT])
                    begin
                        fifo_fill[1] = 0;
                        fifo_head[1] = 0;
                    end
                    mix_word = wdata & MIX_KEEP_MASK;
                end
                else if (addr >= ADDR_SND_LO && addr <= ADDR_SND_HI)
                    snd_regs[(addr - ADDR_SND_LO) >> 1] = wdata;
            end
            OP_TICK_A, OP_TICK_B:
            begin
                ch = (op == OP_TICK_B) ? 1 : 0;
                // Empty FIFO: hold the current sample
                if (fifo_fill[ch] != 0)
                begin
                    cur_sample[ch] = fifo_mem[ch][fifo_head[ch]];
                    fifo_head[ch]  = (fifo_head[ch] + 1) % FIFO_SLOTS;
                    fifo_fill[ch]--;
                end
                r.dma_request = dma && (fifo_fill[ch] < refill_level);
            end
            default: ;
        endcase
        r.sample_a = cur_sample[0];
        r.sample_b = cur_sample[1];
        return r;
    endfunction

    // Send one item; tvalid stays high afterwards so back-to-back transfers need no gap
    task automatic send_item(input op_t op, input logic [7:0] addr,
                             input logic [15:0] wdata, input logic dma);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {7'd0, dma, wdata, addr};
        do
            @(posedge clk);
        while (!s_axis_tready);
        awaited_results.push_back(predict_result(op, addr, wdata, dma));
        items_sent++;
        if (op == OP_TICK_A || op == OP_TICK_B)
            ticks_sent++;
    endtask

    // Hold the sender until every awaited result has come and the block is quiet
    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_refill_threshold(input int unsigned level);
        wait_results_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= level[THRESH_W-1:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid    <= 1'b0;
        refill_level = level;
    endtask

    // Check each result transfer against the oldest prediction; pace the receiver
    always @(posedge clk)
    begin : check_results
        result_t seen;
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            seen = result_t'(m_axis_tdata[RESULT_W-1:0]);
            if (awaited_results.size() == 0)
            begin
                $error("unexpected result transfer, data %h", m_axis_tdata);
                fail_count++;
            end
            else
            begin
                want = awaited_results.pop_front();
                results_checked++;
                if (seen.dma_request)
                    refills_seen++;
                if (seen.read_data !== want.read_data)
                begin
                    $error("read_data: expected %h, got %h", want.read_data, seen.read_data);
                    fail_count++;
                end
                if (seen.sample_a !== want.sample_a)
                begin
                    $error("sample_a: expected %0d, got %0d",
                           $signed(want.sample_a), $signed(seen.sample_a));
                    fail_count++;
                end
                if (seen.sample_b !== want.sample_b)
                begin
                    $error("sample_b: expected %0d, got %0d",
                           $signed(want.sample_b), $signed(seen.sample_b));
                    fail_count++;
                end
                if (seen.dma_request !== want.dma_request)
                begin
                    $error("dma_request: expected %b, got %b",
                           want.dma_request, seen.dma_request);
                    fail_count++;
                end
            end
        end
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Register page: plain registers, odd offsets, master enable, bias, unmapped reads
    task automatic test_register_page();
        send_item(OP_WRITE, 8'h60, 16'hFFFF, 1'b0);
        send_item(OP_WRITE, 8'h87, 16'h1234, 1'b1);   // just past the range: ignored
        send_item(OP_READ,  8'h61, 16'h0000, 1'b0);   // odd offset aliases 0x60
        send_item(OP_WRITE, 8'h85, 16'hA5A5, 1'b0);   // odd neighbour of master enable
        send_item(OP_READ,  8'h85, 16'h0000, 1'b0);
        send_item(OP_READ,  8'h87, 16'hFFFF, 1'b1);
        send_item(OP_WRITE, ADDR_MASTER, 16'hFF7F, 1'b0);
        send_item(OP_READ,  ADDR_MASTER, 16'h0000, 1'b0);
        send_item(OP_WRITE, ADDR_MASTER, 16'h0080, 1'b0);
        send_item(OP_READ,  ADDR_MASTER, 16'h0000, 1'b0);
        send_item(OP_WRITE, ADDR_BIAS, 16'hFFFF, 1'b0);
        send_item(OP_READ,  ADDR_BIAS, 16'h0000, 1'b0);
        send_item(OP_READ,  8'h5F, 16'h0000, 1'b0);
        send_item(OP_READ,  ADDR_FIFO_A0, 16'h0000, 1'b0);   // FIFO ports read as zero
    endtask

    // FIFO paths: empty tick, both sample extremes, both ports, clear through the mix word
    task automatic test_fifo_paths();
        send_item(OP_TICK_A, 8'h00, 16'h0000, 1'b1);
        send_item(OP_WRITE, ADDR_FIFO_A0, 16'h807F, 1'b0);
        send_item(OP_WRITE, ADDR_FIFO_B1, 16'h0180, 1'b0);
        send_item(OP_TICK_A, 8'hFF, 16'hFFFF, 1'b1);
        send_item(OP_TICK_A, 8'h00, 16'h0000, 1'b1);
        send_item(OP_TICK_B, 8'h00, 16'h0000, 1'b0);
        send_item(OP_WRITE, ADDR_FIFO_A1, 16'h5511, 1'b0);
        send_item(OP_WRITE, ADDR_MIX, 16'hFFFF, 1'b0);
        send_item(OP_READ,  ADDR_MIX, 16'h0000, 1'b0);
        send_item(OP_TICK_A, 8'h00, 16'h0000, 1'b1);
        send_item(OP_TICK_B, 8'h00, 16'h0000, 1'b1);
    endtask

    // Threshold at zero, which never requests, and at 32, which always does when DMA is on
    task automatic test_threshold_extremes();
        write_refill_threshold(0);
        send_item(OP_WRITE, ADDR_FIFO_A0, 16'h3322, 1'b0);
        send_item(OP_TICK_A, 8'h00, 16'h0000, 1'b1);
        write_refill_threshold(32);
        send_item(OP_TICK_A, 8'h00, 16'h0000, 1'b1);
        send_item(OP_TICK_B, 8'h00, 16'h0000, 1'b1);
        send_item(OP_TICK_B, 8'h00, 16'h0000, 1'b0);
    endtask

    // Random traffic: mostly FIFO fill and drain bursts, some register work, some noise
    task automatic test_random_traffic(input int target);
        int          sent;
        int          pick;
        int          len;
        int          ch;
        logic [7:0]  addr;
        logic [15:0] word;
        sent = 0;
        while (sent < target)
        begin
            pick = $urandom_range(99);
            ch   = $urandom_range(1);
            if (pick < 35)
            begin
                // Fill burst, long enough at times to overrun the FIFO
                len = $urandom_range(1, 18);
                repeat (len)
                begin
                    if (ch == 0)
                        addr = $urandom_range(1) ? ADDR_FIFO_A1 : ADDR_FIFO_A0;
                    else
                        addr = $urandom_range(1) ? ADDR_FIFO_B1 : ADDR_FIFO_B0;
                    send_item(OP_WRITE, addr, 16'($urandom), 1'($urandom_range(1)));
                end
            end
            else if (pick < 65)
            begin
                // Drain burst, often running past empty
                len = $urandom_range(1, 20);
                repeat (len)
                    send_item(ch ? OP_TICK_B : OP_TICK_A, 8'($urandom), 16'($urandom),
                              1'($urandom_range(1)));
            end
            else if (pick < 82)
            begin
                // Write then read back around the register page
                len  = 2;
                addr = 8'($urandom_range(8'h5E, 8'h8A));
                word = 16'($urandom);
                send_item(OP_WRITE, addr, word, 1'($urandom_range(1)));
                if ($urandom_range(1))
                    addr = addr ^ 8'h01;
                send_item(OP_READ, addr, 16'($urandom), 1'($urandom_range(1)));
            end
            else if (pick < 87)
            begin
                // Mix word write, clearing one, both or neither FIFO
                len = 1;
                send_item(OP_WRITE, ADDR_MIX, 16'($urandom), 1'($urandom_range(1)));
            end
            else
            begin
                len = 1;
                send_item(op_t'($urandom_range(3)), 8'($urandom), 16'($urandom),
                          1'($urandom_range(1)));
            end
            sent += len;
        end
    endtask

    initial
    begin
        for (int i = 0; i < NUM_SOUND_REGS; i++)
            snd_regs[i] = '0;
        bias_word    = '0;
        master_on    = 1'b0;
        mix_word     = '0;
        fifo_fill    = '{0, 0};
        fifo_head    = '{0, 0};
        cur_sample   = '{8'h00, 8'h00};
        refill_level = THRESH_RESET;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_register_page();
        test_fifo_paths();
        test_threshold_extremes();

        // Slow sender against a slow receiver, each in turn, then flat out
        send_idle_pct = 24;
        recv_idle_pct = 62;
        write_refill_threshold($urandom_range(0, 32));
        test_random_traffic(PHASE_ITEMS / 2);
        wait_results_drained();
        test_random_traffic(PHASE_ITEMS / 2);

        send_idle_pct = 62;
        recv_idle_pct = 24;
        write_refill_threshold($urandom_range(0, 32));
        test_random_traffic(PHASE_ITEMS);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_refill_threshold($urandom_range(0, 32));
        test_random_traffic(PHASE_ITEMS);

        wait_results_drained();

        $display("tb: %0d items sent (%0d ticks), %0d results checked, %0d refill requests",
                 items_sent, ticks_sent, results_checked, refills_seen);
        $display("tb: covered register page, FIFO fill, overrun, drain, clear and thresholds");
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/pfsr_pkg.sv
rtl/core/pfsr_cell.sv
rtl/core/pfsr_fifo.sv
rtl/core/pcm_fifo_sound_register_block.sv
rtl/core/pfsr_checker.sv
test/testbench.sv
